// ===== hw/rtl/uds_pkg.sv =====
package uds_pkg;

  // Request and result items as they travel on the channels.
  typedef struct packed {
    logic [7:0] req_byte;
    logic       req_last;
  } uds_req_t;

  typedef struct packed {
    logic [2:0]  out_kind;
    logic [7:0]  resp_byte;
    logic [23:0] flash_offset;
    logic [63:0] flash_data;
    logic        run_last;
  } uds_item_t;

  // Result item kinds.
  localparam logic [2:0] KIND_RESP   = 3'd0;
  localparam logic [2:0] KIND_WRITE8 = 3'd1;
  localparam logic [2:0] KIND_WRITE2 = 3'd2;
  localparam logic [2:0] KIND_ERASE  = 3'd3;
  localparam logic [2:0] KIND_UNLOCK = 3'd4;
  localparam logic [2:0] KIND_LOCK   = 3'd5;
  localparam logic [2:0] KIND_RESET  = 3'd6;

  // Service identifiers.
  localparam logic [7:0] SID_SESSION = 8'h10;
  localparam logic [7:0] SID_ECU_RST = 8'h11;
  localparam logic [7:0] SID_RD_DID  = 8'h22;
  localparam logic [7:0] SID_ROUTINE = 8'h31;
  localparam logic [7:0] SID_DL_REQ  = 8'h34;
  localparam logic [7:0] SID_XFER    = 8'h36;
  localparam logic [7:0] SID_XFER_EX = 8'h37;
  localparam logic [7:0] SID_TP      = 8'h3E;

  // Negative response codes.
  localparam logic [7:0] NEG_RESP     = 8'h7F;
  localparam logic [7:0] NRC_COND     = 8'h22;
  localparam logic [7:0] NRC_SEQ      = 8'h73;
  localparam logic [7:0] NRC_LEN      = 8'h71;

  localparam int unsigned MAX_ITEMS   = 16;
  localparam int unsigned PLAN_DEPTH  = 5;
  localparam logic [15:0] CRC_POLY    = 16'h8005;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_XREAD,
    ST_XTAKE,
    ST_XEMIT,
    ST_PLAN
  } uds_state_t;

  // One byte of the image CRC, most significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    r = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/uds_download_server.sv =====
// Diagnostic download server. Request bytes are taken one per cycle while the
// block is idle and kept in an internal request store of REQUEST_BYTES bytes;
// bytes beyond that are dropped. After the byte marked last, the input is
// stalled while the request is handled: it is decoded, then its result items
// are given out as the output takes them. A transfer-data request reads its
// payload back from the store through its single registered read port, with a
// read state and a take state for each data byte and an emit state for each
// flash write issued. At most 16 result items are given per request; the last
// one carries run_last.
module uds_download_server
  import uds_pkg::*;
#(
  parameter int unsigned REQUEST_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  uds_req_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output uds_item_t out_data
);

  localparam int unsigned LW = $clog2(REQUEST_BYTES + 1);
  localparam int unsigned AW = $clog2(REQUEST_BYTES);
  localparam logic [7:0] MAX_BLK = 8'((REQUEST_BYTES - 1) % 256);

  // Request store.
  logic [7:0] req_mem [REQUEST_BYTES];
  logic [7:0] rd_data_r;
  logic [AW-1:0] rd_addr;

  uds_state_t st_r, st_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [3:0][7:0] hdr_r;
  logic [LW-1:0] size_r, size_nxt;
  logic [LW-1:0] pos_r, pos_nxt;
  logic [2:0] k_r, k_nxt;
  logic w8_r, w8_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [23:0] off_r, off_nxt;
  logic [7:0] seq_r, seq_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic [2:0] pl_kind_r [PLAN_DEPTH];
  logic [2:0] pl_kind_nxt [PLAN_DEPTH];
  logic [7:0] pl_byte_r [PLAN_DEPTH];
  logic [7:0] pl_byte_nxt [PLAN_DEPTH];
  logic [2:0] pl_n_r, pl_n_nxt;
  logic [2:0] idx_r, idx_nxt;

  logic in_acc;
  logic push, out_ok, need;
  uds_item_t item;
  logic [7:0] b1, b2, b3;
  logic [7:0] seq_inc;
  logic [LW-1:0] step, pos_new, dsize;

  assign in_stall = (st_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign need     = (cnt_r < 5'(MAX_ITEMS));
  assign rd_addr  = AW'(pos_r + LW'(k_r) + LW'(2));

  // Request bytes beyond the stored length read as zero.
  assign b1 = (len_r > LW'(1)) ? hdr_r[1] : 8'h00;
  assign b2 = (len_r > LW'(2)) ? hdr_r[2] : 8'h00;
  assign b3 = (len_r > LW'(3)) ? hdr_r[3] : 8'h00;
  assign seq_inc = seq_r + 8'd1;
  assign dsize = (len_r >= LW'(2)) ? len_r - LW'(2) : '0;
  assign step = w8_r ? LW'(8) : LW'(2);
  assign pos_new = pos_r + step;

  // Store writes on accepted bytes; reads are registered.
  always_ff @(posedge clk) begin
    if (in_acc && (len_r < LW'(REQUEST_BYTES))) begin
      req_mem[len_r[AW-1:0]] <= in_data.req_byte;
    end
    rd_data_r <= req_mem[rd_addr];
  end

  // Leading request bytes are also kept aside for decoding.
  always_ff @(posedge clk) begin
    if (in_acc && (len_r < LW'(4))) begin
      hdr_r[len_r[1:0]] <= in_data.req_byte;
    end
  end

  // Sequencer: decode, transfer payload, then emit the planned items.
  always_comb begin
    st_nxt = st_r;
    len_nxt = len_r;
    size_nxt = size_r;
    pos_nxt = pos_r;
    k_nxt = k_r;
    w8_nxt = w8_r;
    acc_nxt = acc_r;
    crc_nxt = crc_r;
    off_nxt = off_r;
    seq_nxt = seq_r;
    cnt_nxt = cnt_r;
    pl_kind_nxt = pl_kind_r;
    pl_byte_nxt = pl_byte_r;
    pl_n_nxt = pl_n_r;
    idx_nxt = idx_r;
    push = 1'b0;
    item = '0;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (len_r < LW'(REQUEST_BYTES)) begin
            len_nxt = len_r + LW'(1);
          end
          if (in_data.req_last) begin
            st_nxt = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        len_nxt = '0;
        cnt_nxt = '0;
        idx_nxt = '0;
        size_nxt = dsize;
        st_nxt = ST_PLAN;
        for (int i = 0; i < PLAN_DEPTH; i++) begin
          pl_kind_nxt[i] = KIND_RESP;
        end
        // Default is the general negative answer.
        pl_n_nxt = 3'd3;
        pl_byte_nxt[0] = NEG_RESP;
        pl_byte_nxt[1] = hdr_r[0];
        pl_byte_nxt[2] = NRC_COND;
        case (hdr_r[0])
          SID_SESSION: begin
            if (b1 == 8'h02) begin
              pl_byte_nxt[0] = 8'h50;
              pl_byte_nxt[1] = 8'h02;
              pl_kind_nxt[2] = KIND_UNLOCK;
              off_nxt = '0;
              seq_nxt = '0;
              crc_nxt = '0;
            end else if (b1 == 8'h01) begin
              pl_n_nxt = 3'd0;
            end
          end
          SID_ECU_RST: begin
            if (b1 == 8'h01) begin
              pl_n_nxt = 3'd2;
              pl_byte_nxt[0] = 8'h51;
              pl_kind_nxt[1] = KIND_RESET;
            end
          end
          SID_RD_DID: begin
            if (b1 == 8'h00 && b2 == 8'h01) begin
              pl_n_nxt = 3'd5;
              pl_byte_nxt[0] = 8'h62;
              pl_byte_nxt[1] = 8'h00;
              pl_byte_nxt[2] = 8'h01;
              pl_byte_nxt[3] = 8'h00;
              pl_byte_nxt[4] = 8'h10;
            end
          end
          SID_ROUTINE: begin
            if (b1 == 8'h01 && b2 == 8'hFF && b3 == 8'h01) begin
              pl_byte_nxt[0] = 8'h71;
              pl_byte_nxt[1] = 8'h01;
              pl_kind_nxt[2] = KIND_ERASE;
              crc_nxt = '0;
            end else if (b1 == 8'h01 && b2 == 8'hFF && b3 == 8'h02) begin
              pl_n_nxt = 3'd4;
              pl_byte_nxt[0] = 8'h71;
              pl_byte_nxt[1] = 8'h02;
              pl_byte_nxt[2] = crc_r[7:0];
              pl_byte_nxt[3] = crc_r[15:8];
            end
          end
          SID_DL_REQ: begin
            if (len_r == LW'(11)) begin
              pl_byte_nxt[0] = 8'h74;
              pl_byte_nxt[1] = 8'h10;
              pl_byte_nxt[2] = MAX_BLK;
            end
          end
          SID_XFER: begin
            seq_nxt = seq_inc;
            if (seq_inc != b1) begin
              pl_byte_nxt[2] = NRC_SEQ;
            end else if (dsize[0]) begin
              pl_byte_nxt[2] = NRC_LEN;
            end else begin
              pl_n_nxt = 3'd2;
              pl_byte_nxt[0] = 8'h76;
              pl_byte_nxt[1] = seq_inc;
              pos_nxt = '0;
              k_nxt = '0;
              acc_nxt = '0;
              w8_nxt = (dsize >= LW'(8));
              if (dsize != '0) begin
                st_nxt = ST_XREAD;
              end
            end
          end
          SID_XFER_EX: begin
            pl_n_nxt = 3'd2;
            pl_kind_nxt[0] = KIND_LOCK;
            pl_byte_nxt[1] = 8'h77;
            off_nxt = '0;
            seq_nxt = '0;
          end
          SID_TP: begin
            pl_n_nxt = 3'd1;
            pl_byte_nxt[0] = 8'h7E;
          end
          default: begin
          end
        endcase
      end
      ST_XREAD: begin
        st_nxt = ST_XTAKE;
      end
      ST_XTAKE: begin
        // Gather one payload byte into the write word and the CRC.
        acc_nxt[8*k_r +: 8] = rd_data_r;
        crc_nxt = crc16_byte(crc_r, rd_data_r);
        if (k_r == (w8_r ? 3'd7 : 3'd1)) begin
          st_nxt = ST_XEMIT;
        end else begin
          k_nxt = k_r + 3'd1;
          st_nxt = ST_XREAD;
        end
      end
      ST_XEMIT: begin
        item.out_kind = w8_r ? KIND_WRITE8 : KIND_WRITE2;
        item.flash_offset = off_r;
        item.flash_data = acc_r;
        item.run_last = (cnt_r == 5'(MAX_ITEMS - 1));
        push = need && out_ok;
        if (!need || out_ok) begin
          off_nxt = off_r + 24'(step);
          pos_nxt = pos_new;
          cnt_nxt = cnt_r + 5'(need);
          k_nxt = '0;
          acc_nxt = '0;
          if (pos_new >= size_r) begin
            st_nxt = ST_PLAN;
          end else begin
            w8_nxt = ((size_r - pos_new) >= LW'(8));
            st_nxt = ST_XREAD;
          end
        end
      end
      ST_PLAN: begin
        if (pl_n_r == 3'd0) begin
          st_nxt = ST_IDLE;
        end else begin
          item.out_kind = pl_kind_r[idx_r];
          item.resp_byte = (pl_kind_r[idx_r] == KIND_RESP) ? pl_byte_r[idx_r] : 8'h00;
          item.run_last = (idx_r == pl_n_r - 3'd1) || (cnt_r == 5'(MAX_ITEMS - 1));
          push = need && out_ok;
          if (!need || out_ok) begin
            cnt_nxt = cnt_r + 5'(need);
            idx_nxt = idx_r + 3'd1;
            if (idx_r == pl_n_r - 3'd1) begin
              st_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      len_r <= '0;
      crc_r <= '0;
      off_r <= '0;
      seq_r <= '0;
      cnt_r <= '0;
      pl_n_r <= '0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      len_r <= len_nxt;
      crc_r <= crc_nxt;
      off_r <= off_nxt;
      seq_r <= seq_nxt;
      cnt_r <= cnt_nxt;
      pl_n_r <= pl_n_nxt;
      idx_r <= idx_nxt;
    end
  end

  // Working registers of the current request.
  always_ff @(posedge clk) begin
    size_r <= size_nxt;
    pos_r <= pos_nxt;
    k_r <= k_nxt;
    w8_r <= w8_nxt;
    acc_r <= acc_nxt;
    pl_kind_r <= pl_kind_nxt;
    pl_byte_r <= pl_byte_nxt;
  end

  uds_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .item     (item),
    .ready    (out_ok),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // The item count never passes the per-request limit.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 5'(MAX_ITEMS))
    else $error("result item count above limit");

  // An item is only loaded into a free output slot.
  assert property (@(posedge clk) disable iff (!rst_n) push |-> out_ok)
    else $error("item loaded into an occupied output slot");

  // Payload reads never run past the data length of the transfer.
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_XREAD) |-> (pos_r < size_r))
    else $error("transfer read beyond the request");

endmodule

// ===== hw/rtl/uds_out_reg.sv =====
module uds_out_reg
  import uds_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  uds_item_t item,
  output logic      ready,
  output logic      out_valid,
  input  logic      out_stall,
  output uds_item_t out_data
);

  logic      valid_r;
  uds_item_t data_r;

  // The slot takes a new item when empty or when its item leaves this cycle.
  assign ready     = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= item;
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import uds_pkg::*;

  localparam int unsigned STORE_BYTES = 64;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  uds_req_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  uds_item_t out_data;

  uds_download_server #(.REQUEST_BYTES(STORE_BYTES)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #6 clk = ~clk;

  // A request byte waiting to be sent; drain_first holds it back until the
  // server has delivered every answer it owes.
  typedef struct {
    uds_req_t byte_in;
    bit       drain_first;
  } pending_t;

  pending_t  pending_q[$];
  uds_item_t reply_q[$];
  int        send_idle_pct = 0;
  int        stall_pct = 0;
  int        hold_off = 0;
  int        errors = 0;
  logic      took = 1'b0;

  // Server state as predicted by the testbench.
  logic [7:0]  req_store [STORE_BYTES];
  int unsigned req_len = 0;
  logic [7:0]  session = '0;
  logic [7:0]  blk_seq = '0;
  logic [23:0] wr_off = '0;
  logic [31:0] dl_size = '0;
  logic [2:0]  tp_seen = '0;
  logic        reset_pending = 1'b0;
  logic [15:0] image_crc = '0;
  int          run_count;

  function automatic logic [7:0] req_at(int unsigned i);
    return (i < req_len) ? req_store[i] : 8'h00;
  endfunction

  task automatic push_reply(logic [2:0] k, logic [7:0] rsp, logic [23:0] off, logic [63:0] d);
    uds_item_t it;
    if (run_count >= MAX_ITEMS) return;
    it.out_kind = k;
    it.resp_byte = rsp;
    it.flash_offset = off;
    it.flash_data = d;
    it.run_last = 1'b0;
    reply_q.push_back(it);
    run_count++;
  endtask

  task automatic say(logic [7:0] b);
    push_reply(KIND_RESP, b, '0, '0);
  endtask

  task automatic refuse(logic [7:0] sid, logic [7:0] code);
    say(NEG_RESP);
    say(sid);
    say(code);
  endtask

  // CRC-16 over the image, polynomial 0x8005, most significant bit first.
  task automatic crc_add(logic [7:0] b);
    logic [15:0] r;
    r = image_crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) r = r[15] ? ((r << 1) ^ 16'h8005) : (r << 1);
    image_crc = r;
  endtask

  // Transfer data: sequence check, length check, then the flash writes and the positive answer.
  task automatic predict_download_block();
    int unsigned size, pos, n;
    logic [63:0] d;
    blk_seq = blk_seq + 8'd1;
    if (blk_seq != req_at(1)) begin
      refuse(SID_XFER, NRC_SEQ);
      return;
    end
    size = (req_len >= 2) ? req_len - 2 : 0;
    if (size[0]) begin
      refuse(SID_XFER, NRC_LEN);
      return;
    end
    pos = 0;
    while (pos < size) begin
      n = (size - pos >= 8) ? 8 : 2;
      d = '0;
      for (int unsigned k = 0; k < n; k++) begin
        d[8*k +: 8] = req_at(2 + pos + k);
        crc_add(req_at(2 + pos + k));
      end
      push_reply((n == 8) ? KIND_WRITE8 : KIND_WRITE2, '0, wr_off, d);
      wr_off = wr_off + 24'(n);
      pos += n;
    end
    say(8'h76);
    say(blk_seq);
  endtask

  task automatic predict_service();
    logic [7:0] sid;
    sid = req_at(0);
    case (sid)
      SID_SESSION: begin
        session = req_at(1);
        if (session == 8'h02) begin
          say(8'h50);
          say(session);
          push_reply(KIND_UNLOCK, '0, '0, '0);
          wr_off = '0;
          blk_seq = '0;
          image_crc = '0;
        end else if (session != 8'h01) begin
          refuse(sid, NRC_COND);
        end
      end
      SID_ECU_RST: begin
        if (req_at(1) == 8'h01) begin
          reset_pending = 1'b1;
          say(8'h51);
          push_reply(KIND_RESET, '0, '0, '0);
        end else begin
          refuse(sid, NRC_COND);
        end
      end
      SID_RD_DID: begin
        if (req_at(1) == 8'h00 && req_at(2) == 8'h01) begin
          say(8'h62); say(8'h00); say(8'h01); say(8'h00); say(8'h10);
        end else begin
          refuse(sid, NRC_COND);
        end
      end
      SID_ROUTINE: begin
        if (req_at(1) == 8'h01 && req_at(2) == 8'hFF && req_at(3) == 8'h01) begin
          say(8'h71); say(8'h01);
          push_reply(KIND_ERASE, '0, '0, '0);
          image_crc = '0;
        end else if (req_at(1) == 8'h01 && req_at(2) == 8'hFF && req_at(3) == 8'h02) begin
          say(8'h71); say(8'h02);
          say(image_crc[7:0]);
          say(image_crc[15:8]);
        end else begin
          refuse(sid, NRC_COND);
        end
      end
      SID_DL_REQ: begin
        if (req_len != 11) begin
          refuse(sid, NRC_COND);
        end else begin
          dl_size = {req_at(10), req_at(9), req_at(8), req_at(7)};
          say(8'h74); say(8'h10); say(8'(STORE_BYTES - 1));
        end
      end
      SID_XFER: predict_download_block();
      SID_XFER_EX: begin
        push_reply(KIND_LOCK, '0, '0, '0);
        session = 8'h01;
        wr_off = '0;
        blk_seq = '0;
        say(8'h77);
      end
      SID_TP: begin
        say(8'h7E);
        tp_seen = 3'd5;
      end
      default: refuse(sid, NRC_COND);
    endcase
  endtask

  // One accepted request byte; the last one triggers the decode.
  task automatic predict_request_byte(uds_req_t r);
    int first;
    if (req_len < STORE_BYTES) begin
      req_store[req_len] = r.req_byte;
      req_len++;
    end
    if (!r.req_last) return;
    first = reply_q.size();
    run_count = 0;
    predict_service();
    req_len = 0;
    if (reply_q.size() > first) reply_q[$].run_last = 1'b1;
  endtask

  task automatic check_reply(uds_item_t got);
    uds_item_t want;
    if (reply_q.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    want = reply_q.pop_front();
    if (got.out_kind !== want.out_kind) begin
      $display("%0t: out_kind expected %0d got %0d", $time, want.out_kind, got.out_kind);
      errors++;
    end
    if (got.resp_byte !== want.resp_byte) begin
      $display("%0t: resp_byte expected %h got %h", $time, want.resp_byte, got.resp_byte);
      errors++;
    end
    if (got.flash_offset !== want.flash_offset) begin
      $display("%0t: flash_offset expected %h got %h", $time, want.flash_offset,
               got.flash_offset);
      errors++;
    end
    if (got.flash_data !== want.flash_data) begin
      $display("%0t: flash_data expected %h got %h", $time, want.flash_data, got.flash_data);
      errors++;
    end
    if (got.run_last !== want.run_last) begin
      $display("%0t: run_last expected %b got %b", $time, want.run_last, got.run_last);
      errors++;
    end
  endtask

  // Sampling at the rising edge: request transfers feed the predictor, result
  // transfers are checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_request_byte(in_data);
      if (out_valid && !out_stall) check_reply(out_data);
      took <= in_valid && !in_stall;
    end
  end

  // Request driver: a new byte is offered only once the current one is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || took)) begin
      if (pending_q.size() > 0 && !(pending_q[0].drain_first && reply_q.size() != 0) &&
          $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_q[0].byte_in;
        pending_q.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall, with an optional long hold-off.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off = hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Stimulus generation, tracking the block sequence the server will expect.
  logic [7:0] gen_seq = '0;
  int         gen_bytes = 0;
  logic [7:0] msg[$];

  task automatic queue_request(bit drain);
    pending_t p;
    foreach (msg[i]) begin
      p.byte_in.req_byte = msg[i];
      p.byte_in.req_last = (i == msg.size() - 1);
      p.drain_first = drain && (i == 0);
      pending_q.push_back(p);
      gen_bytes++;
    end
    if (msg.size() > 0 && msg[0] == SID_XFER) gen_seq = gen_seq + 8'd1;
    if (msg.size() > 1 && msg[0] == SID_SESSION && msg[1] == 8'h02) gen_seq = '0;
    if (msg.size() > 0 && msg[0] == SID_XFER_EX) gen_seq = '0;
    msg.delete();
  endtask

  task automatic random_request();
    int n;
    case ($urandom_range(11))
      0: msg = '{SID_SESSION, ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2))};
      1: msg = '{SID_ECU_RST, ($urandom_range(1) == 0) ? 8'h01 : 8'($urandom)};
      2: msg = '{SID_RD_DID, 8'h00, ($urandom_range(3) == 0) ? 8'($urandom) : 8'h01};
      3: msg = '{SID_ROUTINE, 8'h01, 8'hFF, 8'($urandom_range(1, 2))};
      4: begin
        n = ($urandom_range(4) == 0) ? $urandom_range(1, 14) : 11;
        msg.push_back(SID_DL_REQ);
        repeat (n - 1) msg.push_back(8'($urandom));
      end
      5, 6, 7, 8: begin
        n = ($urandom_range(7) == 0) ? 2 * $urandom_range(8, 31) : 2 * $urandom_range(0, 7);
        if ($urandom_range(9) == 0) n++;
        msg.push_back(SID_XFER);
        msg.push_back(($urandom_range(11) == 0) ? 8'($urandom) : gen_seq + 8'd1);
        repeat (n) msg.push_back(8'($urandom));
      end
      9: msg = '{SID_XFER_EX};
      10: msg = '{SID_TP};
      default: begin
        n = $urandom_range(1, 5);
        repeat (n) msg.push_back(8'($urandom));
      end
    endcase
    queue_request($urandom_range(7) == 0);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || reply_q.size() != 0 || in_valid) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests: each service, its refusals and the corner cases.
    msg = '{SID_SESSION, 8'h02};                      queue_request(0);
    msg = '{SID_RD_DID, 8'h00, 8'h01};                queue_request(0);
    msg = '{SID_RD_DID, 8'h00};                       queue_request(0); // missing byte
    msg = '{SID_DL_REQ, 8'h00, 8'h44, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'h80, 8'hFF, 8'h00, 8'h7F};              queue_request(0);
    msg = '{SID_DL_REQ, 8'h00};                       queue_request(0);
    msg = '{SID_XFER, 8'h01, 8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE,
            8'h12, 8'h34};                            queue_request(0);
    msg = '{SID_XFER, 8'h02, 8'h11, 8'h22, 8'h33};    queue_request(0); // odd length
    msg = '{SID_XFER};                                queue_request(0); // short transfer
    msg = '{SID_XFER, 8'h04};                         queue_request(0); // no data
    msg = '{SID_XFER, 8'h09};                         queue_request(0); // sequence error
    msg = '{SID_ROUTINE, 8'h01, 8'hFF, 8'h02};        queue_request(1);
    msg = '{SID_ROUTINE, 8'h01, 8'hFF, 8'h01};        queue_request(0);
    msg = '{SID_ROUTINE, 8'h00};                      queue_request(0);
    msg = '{SID_TP};                                  queue_request(0);
    msg = '{SID_XFER_EX};                             queue_request(0);
    msg = '{SID_SESSION, 8'h01};                      queue_request(0);
    msg = '{SID_SESSION, 8'hFF};                      queue_request(0);
    msg = '{SID_ECU_RST, 8'h01};                      queue_request(0);
    msg = '{SID_ECU_RST, 8'h00};                      queue_request(0);
    msg = '{8'h00};                                   queue_request(0);
    msg = '{SID_SESSION, 8'h02};                      queue_request(0);
    // Overlong transfer: bytes past the store are dropped.
    msg = '{SID_XFER, 8'h01};
    repeat (63) msg.push_back(8'($urandom));
    queue_request(0);
    wait_drained();

    // Random phases: free flow after a long hold-off, idle sender, stalling receiver, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 81 : 17) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 81 : 17) : 0;
      if (ph == 0) hold_off = 400;
      gen_bytes = 0;
      msg = '{SID_SESSION, 8'h02};
      queue_request(1);
      while (gen_bytes < 6) random_request();
      wait_drained();
    end

    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/uds_pkg.sv
hw/rtl/uds_out_reg.sv
hw/rtl/uds_download_server.sv
verif/testbench.sv
